// ===== design/ffha_pkg.sv =====
// Shared types, constants and helper functions for the first-fit heap allocator.
// It has no dependencies. The controller, the datapath and the top level all use it.
package ffha_pkg;

	localparam int HEAP_BYTES     = 512;
	localparam int HEADER_BYTES   = 9;
	localparam int MAX_READ_BYTES = 64;

	// Header field bytes: size (2), id (2) and mark (1). The rest of the header is zero.
	localparam int HDR_FIELD_BYTES = 5;
	localparam int MARK_OFFSET     = 4;

	localparam logic [7:0] MARK_USED  = 8'h79;
	localparam logic [7:0] MARK_FREE  = 8'h6E;
	localparam logic [7:0] FILL_BLANK = 8'h20;

	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_WRITE = 2'd2;
	localparam logic [1:0] FN_READ  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SPACE  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
	localparam logic [2:0] ST_TOO_SMALL = 3'd4;
	localparam logic [2:0] ST_CLAMPED   = 3'd5;
	localparam logic [2:0] ST_IDS_OUT   = 3'd6;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd7;

	typedef struct packed {
		logic [1:0]  func;
		logic [8:0]  req_size;
		logic [15:0] target_id;
		logic [7:0]  fill_byte;
		logic [8:0]  byte_count;
		logic [8:0]  byte_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] new_id;
		logic [8:0]  granted_size;
		logic [7:0]  data_byte;
		logic        last_result;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_LATCH     = 4'd1,
		OP_WALK_INIT = 4'd2,
		OP_HDR_READ  = 4'd3,
		OP_ADVANCE   = 4'd4,
		OP_FIT       = 4'd5,
		OP_APPEND    = 4'd6,
		OP_W_SPLIT   = 4'd7,
		OP_W_HEAD    = 4'd8,
		OP_W_FILL    = 4'd9,
		OP_W_FREE    = 4'd10,
		OP_W_WFILL   = 4'd11,
		OP_RD_SETUP  = 4'd12,
		OP_RD_ISSUE  = 4'd13
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       emit;
		logic [2:0] st;
		logic       with_id;
		logic       with_data;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [1:0] func;
		logic       req_zero;
		logic       id_exhausted;
		logic       tid_zero;
		logic       pos_in_range;
		logic       hdr_rd_done;
		logic       alloc_fit;
		logic       split;
		logic       id_match;
		logic       mark_used;
		logic       wr_too_long;
		logic       no_space;
		logic       hdr_wr_done;
		logic       fill_done;
		logic       wfill_done;
		logic       rd_empty;
		logic       rd_last;
		logic [2:0] rd_st;
	} stat_t;

	// One byte of a block header, by its offset within the header.
	function automatic logic [7:0] hdr_byte(input logic [4:0] k, input logic [15:0] size,
			input logic [15:0] id, input logic [7:0] mark);
		logic [7:0] b;
		case (k)
			5'd0: b = size[7:0];
			5'd1: b = size[15:8];
			5'd2: b = id[7:0];
			5'd3: b = id[15:8];
			5'd4: b = mark;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== design/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: the controller and the datapath joined.
// It depends on ffha_pkg, ffha_ctrl, ffha_datapath and, through the datapath, ffha_ram.
//
//   channel | handshake             | word                      | role
//   --------+-----------------------+---------------------------+---------------------------
//   req     | req_valid / req_ready | ffha_pkg::req_t           | allocate, free, write, read
//   rsp     | rsp_valid / rsp_ready | ffha_pkg::rsp_t           | one or more result words
//
// For every block header it walks past, a request makes a range check, five byte reads of
// the heap RAM, a step to take in the last byte and a decision; for every header written it
// makes nine byte writes and a done check. It clears or fills one payload byte per cycle,
// and streams each read byte by an issue step and a wait for the output register.
// Reset clears the used end to zero and the next id to one; the heap RAM is not cleared.
// A full output register stalls the sequencer until the word is taken; a new request is
// accepted while the last result word of the previous one still waits.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES     = ffha_pkg::HEAP_BYTES,
	parameter int HEADER_BYTES   = ffha_pkg::HEADER_BYTES,
	parameter int MAX_READ_BYTES = ffha_pkg::MAX_READ_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffha_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffha_pkg::rsp_t rsp
);

	// Commands flow from the sequencer to the datapath; compare results flow back.
	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t stat;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the heap memory, the block walk pointer and the result register.
	ffha_datapath #(
		.HEAP_BYTES    (HEAP_BYTES),
		.HEADER_BYTES  (HEADER_BYTES),
		.MAX_READ_BYTES(MAX_READ_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word (rsp)
	);

endmodule

// ===== design/ffha_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/ffha_datapath.sv =====
// Datapath of the heap allocator: heap RAM, walk pointer, header fields, counters and the
// result register. It depends on ffha_pkg and ffha_ram and acts on commands from ffha_ctrl.
module ffha_datapath #(
	parameter int HEAP_BYTES     = ffha_pkg::HEAP_BYTES,
	parameter int HEADER_BYTES   = ffha_pkg::HEADER_BYTES,
	parameter int MAX_READ_BYTES = ffha_pkg::MAX_READ_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffha_pkg::req_t  req_word,
	input  ffha_pkg::cmd_t  cmd,
	output ffha_pkg::stat_t stat,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ffha_pkg::rsp_t  rsp_word
);

	localparam int AW  = $clog2(HEAP_BYTES);
	localparam int PW  = AW + 1;
	localparam int XW  = ((PW > 16) ? PW : 16) + 2;
	localparam int RCW = $clog2(MAX_READ_BYTES + 1);

	ffha_pkg::req_t req_q;
	ffha_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  used_end_q;
	logic [PW-1:0]  cnt_q;
	logic [15:0]    next_id_q;
	logic [15:0]    size_q;
	logic [15:0]    hid_q;
	logic [7:0]     mark_q;
	logic [15:0]    grant_q;
	logic [RCW-1:0] rcnt_q;
	logic [2:0]     rst_q;

	logic [XW-1:0] x_pos, x_used, x_size, x_req, x_hdr, x_cnt, x_off, x_cntb;
	logic [XW-1:0] avail, rd_len, waddr_x, raddr_x;
	logic [2:0]    rd_st_d;
	logic [15:0]   split_size, grant_fit;
	logic          out_free, split, we, re;
	logic [7:0]    wdata, rdata;

	assign x_pos  = XW'(pos_q);
	assign x_used = XW'(used_end_q);
	assign x_size = XW'(size_q);
	assign x_req  = XW'(req_q.req_size);
	assign x_hdr  = XW'(HEADER_BYTES);
	assign x_cnt  = XW'(cnt_q);
	assign x_off  = XW'(req_q.byte_offset);
	assign x_cntb = XW'(req_q.byte_count);

	assign out_free   = !rsp_valid_q || rsp_ready;
	assign split      = x_size > x_req + x_hdr;
	assign split_size = 16'(size_q - 16'(req_q.req_size) - 16'(HEADER_BYTES));
	assign grant_fit  = (x_size == x_req || split) ? 16'(req_q.req_size) : size_q;

	// Clamp the read length to the payload left past the offset and to the read limit.
	always_comb begin
		avail   = (x_off < x_size) ? x_size - x_off : '0;
		rd_len  = x_cntb;
		rd_st_d = ffha_pkg::ST_OK;
		if (rd_len > avail) begin
			rd_len  = avail;
			rd_st_d = ffha_pkg::ST_CLAMPED;
		end
		if (rd_len > XW'(MAX_READ_BYTES)) begin
			rd_len  = XW'(MAX_READ_BYTES);
			rd_st_d = ffha_pkg::ST_CLAMPED;
		end
	end

	always_comb begin
		stat.out_free     = out_free;
		stat.func         = req_q.func;
		stat.req_zero     = req_q.req_size == '0;
		stat.id_exhausted = next_id_q == '0;
		stat.tid_zero     = req_q.target_id == '0;
		stat.pos_in_range = x_pos + x_hdr <= x_used;
		stat.hdr_rd_done  = x_cnt == XW'(ffha_pkg::HDR_FIELD_BYTES);
		stat.alloc_fit    = mark_q != ffha_pkg::MARK_USED && x_size >= x_req;
		stat.split        = split;
		stat.id_match     = hid_q == req_q.target_id;
		stat.mark_used    = mark_q == ffha_pkg::MARK_USED;
		stat.wr_too_long  = x_cntb > x_size;
		stat.no_space     = x_used + x_hdr + x_req > XW'(HEAP_BYTES);
		stat.hdr_wr_done  = x_cnt == x_hdr;
		stat.fill_done    = x_cnt == XW'(grant_q);
		stat.wfill_done   = x_cnt == x_cntb;
		stat.rd_empty     = rcnt_q == '0;
		stat.rd_last      = x_cnt + XW'(1) == XW'(rcnt_q);
		stat.rd_st        = rst_q;
	end

	always_comb begin
		we      = 1'b0;
		waddr_x = x_pos + x_hdr + x_cnt;
		wdata   = ffha_pkg::FILL_BLANK;
		case (cmd.op)
			ffha_pkg::OP_W_SPLIT: begin
				we      = 1'b1;
				waddr_x = x_pos + x_hdr + x_req + x_cnt;
				wdata   = ffha_pkg::hdr_byte(5'(cnt_q), split_size, 16'h0000,
					ffha_pkg::MARK_FREE);
			end
			ffha_pkg::OP_W_HEAD: begin
				we      = 1'b1;
				waddr_x = x_pos + x_cnt;
				wdata   = ffha_pkg::hdr_byte(5'(cnt_q), grant_q, next_id_q,
					ffha_pkg::MARK_USED);
			end
			ffha_pkg::OP_W_FILL: begin
				we = 1'b1;
			end
			ffha_pkg::OP_W_WFILL: begin
				we    = 1'b1;
				wdata = req_q.fill_byte;
			end
			ffha_pkg::OP_W_FREE: begin
				we      = 1'b1;
				waddr_x = x_pos + XW'(ffha_pkg::MARK_OFFSET);
				wdata   = ffha_pkg::MARK_FREE;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign re = (cmd.op == ffha_pkg::OP_HDR_READ && x_cnt < XW'(ffha_pkg::HDR_FIELD_BYTES))
		|| cmd.op == ffha_pkg::OP_RD_ISSUE;
	assign raddr_x = (cmd.op == ffha_pkg::OP_RD_ISSUE) ? x_pos + x_hdr + x_off + x_cnt
		: x_pos + x_cnt;

	ffha_ram #(
		.WIDTH(8),
		.DEPTH(HEAP_BYTES)
	) u_heap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr_x[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr_x[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			used_end_q  <= '0;
			cnt_q       <= '0;
			next_id_q   <= 16'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (cmd.op)
				ffha_pkg::OP_WALK_INIT: pos_q <= '0;
				ffha_pkg::OP_ADVANCE:   pos_q <= PW'(x_pos + x_hdr + x_size);
				ffha_pkg::OP_APPEND: begin
					pos_q      <= used_end_q;
					used_end_q <= PW'(x_used + x_hdr + x_req);
				end
				default: begin
				end
			endcase
			if (cmd.emit && cmd.with_id) begin
				next_id_q <= next_id_q + 16'd1;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::OP_LATCH: req_q <= req_word;
			ffha_pkg::OP_HDR_READ: begin
				if (cnt_q != '0) begin
					case (cnt_q - 1'b1)
						PW'(0): size_q[7:0]  <= rdata;
						PW'(1): size_q[15:8] <= rdata;
						PW'(2): hid_q[7:0]   <= rdata;
						PW'(3): hid_q[15:8]  <= rdata;
						PW'(4): mark_q       <= rdata;
						default: begin
						end
					endcase
				end
			end
			ffha_pkg::OP_FIT:    grant_q <= grant_fit;
			ffha_pkg::OP_APPEND: grant_q <= 16'(req_q.req_size);
			ffha_pkg::OP_RD_SETUP: begin
				rcnt_q <= RCW'(rd_len);
				rst_q  <= rd_st_d;
			end
			default: begin
			end
		endcase
		if (cmd.emit) begin
			rsp_q.status       <= cmd.st;
			rsp_q.new_id       <= cmd.with_id ? next_id_q : 16'h0000;
			rsp_q.granted_size <= cmd.with_id ? grant_q[8:0] : 9'd0;
			rsp_q.data_byte    <= cmd.with_data ? rdata : 8'h00;
			rsp_q.last_result  <= cmd.last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result written while the output register still holds a word");

	a_pos_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= used_end_q)
		else $error("walk pointer beyond the used end of the heap");

	a_used_end_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(used_end_q) <= XW'(HEAP_BYTES))
		else $error("used end beyond the heap");

	a_id_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && cmd.with_id) |=> $stable(next_id_q))
		else $error("next id changed without a granted allocation");

endmodule

// ===== design/ffha_ctrl.sv =====
// Controller state machine of the heap allocator: sequences header walks, header and fill
// writes and read streams. It depends on ffha_pkg and drives ffha_datapath by commands.
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ffha_pkg::stat_t stat,
	output ffha_pkg::cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_DISP   = 14'b00000000000010,
		S_CHK    = 14'b00000000000100,
		S_HDR    = 14'b00000000001000,
		S_EVAL   = 14'b00000000010000,
		S_APPEND = 14'b00000000100000,
		S_SPLIT  = 14'b00000001000000,
		S_HEAD   = 14'b00000010000000,
		S_FILL   = 14'b00000100000000,
		S_FREE   = 14'b00001000000000,
		S_WFILL  = 14'b00010000000000,
		S_RCHK   = 14'b00100000000000,
		S_RISSUE = 14'b01000000000000,
		S_RWAIT  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.op        = ffha_pkg::OP_NONE;
		cmd.last      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = ffha_pkg::OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.func == ffha_pkg::FN_ALLOC && stat.req_zero) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.st   = ffha_pkg::ST_BAD_SIZE;
						state_d  = S_IDLE;
					end
				end else if (stat.func == ffha_pkg::FN_ALLOC && stat.id_exhausted) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.st   = ffha_pkg::ST_IDS_OUT;
						state_d  = S_IDLE;
					end
				end else if (stat.func != ffha_pkg::FN_ALLOC && stat.tid_zero) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.st   = ffha_pkg::ST_NOT_FOUND;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.op  = ffha_pkg::OP_WALK_INIT;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.pos_in_range) begin
					state_d = S_HDR;
				end else if (stat.func == ffha_pkg::FN_ALLOC) begin
					state_d = S_APPEND;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.st   = ffha_pkg::ST_NOT_FOUND;
					state_d  = S_IDLE;
				end
			end
			S_HDR: begin
				cmd.op      = ffha_pkg::OP_HDR_READ;
				cmd.cnt_inc = 1'b1;
				if (stat.hdr_rd_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.func == ffha_pkg::FN_ALLOC) begin
					if (stat.alloc_fit) begin
						cmd.op  = ffha_pkg::OP_FIT;
						state_d = stat.split ? S_SPLIT : S_HEAD;
					end else begin
						cmd.op  = ffha_pkg::OP_ADVANCE;
						state_d = S_CHK;
					end
				end else if (!stat.id_match) begin
					cmd.op  = ffha_pkg::OP_ADVANCE;
					state_d = S_CHK;
				end else if (stat.func == ffha_pkg::FN_FREE) begin
					state_d = S_FREE;
				end else if (!stat.mark_used) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.st   = ffha_pkg::ST_NOT_ALLOC;
						state_d  = S_IDLE;
					end
				end else if (stat.func == ffha_pkg::FN_WRITE) begin
					if (!stat.wr_too_long) begin
						state_d = S_WFILL;
					end else if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.st   = ffha_pkg::ST_TOO_SMALL;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.op  = ffha_pkg::OP_RD_SETUP;
					state_d = S_RCHK;
				end
			end
			S_APPEND: begin
				if (!stat.no_space) begin
					cmd.op  = ffha_pkg::OP_APPEND;
					state_d = S_HEAD;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.st   = ffha_pkg::ST_NO_SPACE;
					state_d  = S_IDLE;
				end
			end
			S_SPLIT: begin
				if (stat.hdr_wr_done) begin
					state_d = S_HEAD;
				end else begin
					cmd.op      = ffha_pkg::OP_W_SPLIT;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_HEAD: begin
				if (stat.hdr_wr_done) begin
					state_d = S_FILL;
				end else begin
					cmd.op      = ffha_pkg::OP_W_HEAD;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_FILL: begin
				if (!stat.fill_done) begin
					cmd.op      = ffha_pkg::OP_W_FILL;
					cmd.cnt_inc = 1'b1;
				end else if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.st      = ffha_pkg::ST_OK;
					cmd.with_id = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_FREE: begin
				cmd.op = ffha_pkg::OP_W_FREE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.st   = ffha_pkg::ST_OK;
					state_d  = S_IDLE;
				end
			end
			S_WFILL: begin
				if (!stat.wfill_done) begin
					cmd.op      = ffha_pkg::OP_W_WFILL;
					cmd.cnt_inc = 1'b1;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.st   = ffha_pkg::ST_OK;
					state_d  = S_IDLE;
				end
			end
			S_RCHK: begin
				if (!stat.rd_empty) begin
					state_d = S_RISSUE;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.st   = stat.rd_st;
					state_d  = S_IDLE;
				end
			end
			S_RISSUE: begin
				cmd.op  = ffha_pkg::OP_RD_ISSUE;
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.st        = stat.rd_st;
					cmd.with_data = 1'b1;
					cmd.last      = stat.rd_last;
					cmd.cnt_inc   = 1'b1;
					state_d       = stat.rd_last ? S_IDLE : S_RISSUE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// The byte counter restarts on every change of phase, except between the two
		// halves of one read-stream step.
		cmd.cnt_clr = (state_d != state_q)
			&& !(state_q == S_RISSUE && state_d == S_RWAIT)
			&& !(state_q == S_RWAIT && state_d == S_RISSUE);
	end

endmodule
